[hdl/srcd_pkg.sv]
// ----------------------------------------------------------------------------
// srcd_pkg
// Shared constants, command codes and item types for the shift register
// chain driver.
// ----------------------------------------------------------------------------
`default_nettype none

package srcd_pkg;

  // Chain geometry
  localparam int unsigned CHAIN_BYTES = 4;
  localparam int unsigned WRITE_LIMIT = (CHAIN_BYTES < 4) ? CHAIN_BYTES : 4;
  localparam int unsigned LEN_W       = 3;
  localparam int unsigned HP_W        = 16;
  localparam int unsigned TICK_W      = HP_W + 1;

  // Command codes
  localparam logic [2:0] FUNC_WRITE  = 3'd0;
  localparam logic [2:0] FUNC_SET    = 3'd1;
  localparam logic [2:0] FUNC_RESET  = 3'd2;
  localparam logic [2:0] FUNC_TOGGLE = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;
  localparam logic [2:0] FUNC_ENABLE = 3'd5;
  localparam logic [2:0] FUNC_READ   = 3'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = HP_W;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_PRESENT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH_PRESENT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_PRESENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PRESENT = 3'd4;

  // Input item
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] word_value;
    logic [2:0]  byte_count;
    logic [4:0]  bit_index;
    logic        enable_level;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic shift_valid;
    logic serial_bit;
    logic latch_pulse;
    logic clear_pulse;
    logic enable_pin;
    logic read_value;
    logic enable_state;
    logic last;
  } out_item_t;

  // Shadow store status toward the sequencer
  typedef struct packed {
    logic [7:0]       rd_byte;
    logic             rd_bit;
    logic [LEN_W-1:0] send_n;
    logic             enable;
  } shadow_status_t;

endpackage

`default_nettype wire

[hdl/srcd_tick.sv]
// ----------------------------------------------------------------------------
// srcd_tick
// Pin timing counter: loaded with a hold time, counts down to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module srcd_tick (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire logic [srcd_pkg::TICK_W-1:0] load_val_i,
  output logic                             done_o
);

  logic [srcd_pkg::TICK_W-1:0] cnt_q, cnt_d;

  // Reload has priority, otherwise count down and park at zero
  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = load_val_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - srcd_pkg::TICK_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign done_o = (cnt_q == '0);

endmodule

`default_nettype wire

[hdl/srcd_shadow.sv]
// ----------------------------------------------------------------------------
// srcd_shadow
// Shadow copy of the chain, used length and output enable flag. Applies a
// command when an item is accepted and reports what must be sent.
// ----------------------------------------------------------------------------
`default_nettype none

module srcd_shadow (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       upd_i,
  input  wire srcd_pkg::in_item_t         item_i,
  input  wire logic [srcd_pkg::LEN_W-1:0] rd_addr_i,
  output srcd_pkg::shadow_status_t        status_o
);

  logic [7:0]                 shadow_q [srcd_pkg::CHAIN_BYTES];
  logic [7:0]                 shadow_d [srcd_pkg::CHAIN_BYTES];
  logic [srcd_pkg::LEN_W-1:0] used_q, used_d;
  logic                       enable_q, enable_d;

  logic [srcd_pkg::LEN_W-1:0] idx;
  logic [srcd_pkg::LEN_W-1:0] idx_len;
  logic [srcd_pkg::LEN_W-1:0] wr_cnt;
  logic [srcd_pkg::LEN_W-1:0] bit_len;
  logic [srcd_pkg::LEN_W-1:0] send_n;
  logic                       bit_ok;
  logic [7:0]                 mask;
  logic [7:0]                 rd_byte;

  // Command decode and next state
  always_comb begin
    idx     = srcd_pkg::LEN_W'(item_i.bit_index[4:3]);
    idx_len = idx + srcd_pkg::LEN_W'(1);
    mask    = 8'b1 << item_i.bit_index[2:0];
    wr_cnt  = (item_i.byte_count > srcd_pkg::LEN_W'(srcd_pkg::WRITE_LIMIT)) ?
              srcd_pkg::LEN_W'(srcd_pkg::WRITE_LIMIT) : item_i.byte_count;
    bit_ok  = (idx < srcd_pkg::LEN_W'(srcd_pkg::WRITE_LIMIT));
    bit_len = (used_q < idx_len) ? idx_len : used_q;

    shadow_d = shadow_q;
    used_d   = used_q;
    enable_d = enable_q;
    send_n   = '0;

    unique case (item_i.func)
      srcd_pkg::FUNC_WRITE: begin
        for (int i = 0; i < srcd_pkg::CHAIN_BYTES; i++) begin
          if (srcd_pkg::LEN_W'(i) < wr_cnt) begin
            shadow_d[i] = 8'(item_i.word_value >> (8 * i));
          end
        end
        if (used_q < wr_cnt) begin
          used_d = wr_cnt;
        end
        send_n = wr_cnt;
      end
      srcd_pkg::FUNC_SET, srcd_pkg::FUNC_RESET, srcd_pkg::FUNC_TOGGLE: begin
        if (bit_ok) begin
          used_d = bit_len;
          send_n = bit_len;
          for (int i = 0; i < srcd_pkg::CHAIN_BYTES; i++) begin
            if (srcd_pkg::LEN_W'(i) == idx) begin
              if (item_i.func == srcd_pkg::FUNC_SET) begin
                shadow_d[i] = shadow_q[i] | mask;
              end else if (item_i.func == srcd_pkg::FUNC_RESET) begin
                shadow_d[i] = shadow_q[i] & ~mask;
              end else begin
                shadow_d[i] = shadow_q[i] ^ mask;
              end
            end
          end
        end
      end
      srcd_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < srcd_pkg::CHAIN_BYTES; i++) begin
          shadow_d[i] = '0;
        end
      end
      srcd_pkg::FUNC_ENABLE: begin
        enable_d = item_i.enable_level;
      end
      default: begin
        // read and unknown commands leave the state alone
      end
    endcase
  end

  // Single read port: requested byte during idle, chain byte while sending
  always_comb begin
    rd_byte = '0;
    for (int i = 0; i < srcd_pkg::CHAIN_BYTES; i++) begin
      if (srcd_pkg::LEN_W'(i) == rd_addr_i) begin
        rd_byte = shadow_q[i];
      end
    end
  end

  assign status_o.rd_byte = rd_byte;
  assign status_o.rd_bit  = (rd_addr_i < used_q) ? rd_byte[item_i.bit_index[2:0]] : 1'b0;
  assign status_o.send_n  = send_n;
  assign status_o.enable  = enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < srcd_pkg::CHAIN_BYTES; i++) begin
        shadow_q[i] <= '0;
      end
      used_q   <= '0;
      enable_q <= 1'b0;
    end else if (upd_i) begin
      shadow_q <= shadow_d;
      used_q   <= used_d;
      enable_q <= enable_d;
    end
  end

endmodule

`default_nettype wire

[hdl/shift_register_chain_driver_core.sv]
// ----------------------------------------------------------------------------
// shift_register_chain_driver_core
// Command driven controller for a chain of serial-in parallel-out shift
// registers, emitting one result item per serial bit or pin event.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | in        | in_valid_i / in_ready_o   | in_item_i  (in_item_t)
//  out     | out       | out_valid_o / out_ready_i | out_item_o (out_item_t)
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Each result waits on the pin timer, loaded with twice the half period for
//  a shifted bit and with the half period for any other result. One item is
//  in work at a time; the input is ready only while the sequencer is idle. A
//  stalled output holds the timer result until taken. Reset sets all control
//  state at once, no sweep; the result payload register has no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_register_chain_driver_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire srcd_pkg::in_item_t                   in_item_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output srcd_pkg::out_item_t                       out_item_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [srcd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [srcd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Configuration registers
  logic [srcd_pkg::HP_W-1:0] half_period_q;
  logic                      shift_present_q;
  logic                      latch_present_q;
  logic                      clear_present_q;
  logic                      enable_present_q;

  // Sequencer
  logic                       state_q;
  logic                       chain_q;
  logic [srcd_pkg::LEN_W-1:0] byte_q;
  logic [2:0]                 bit_q;
  logic                       clr_q;
  logic                       rdv_q;

  // Output register
  logic                 out_valid_q;
  srcd_pkg::out_item_t  out_q;

  srcd_pkg::shadow_status_t    status;
  logic [srcd_pkg::LEN_W-1:0]  rd_addr;
  logic                        accept_in;
  logic                        out_free;
  logic                        tick_done;
  logic                        tick_load;
  logic [srcd_pkg::TICK_W-1:0] tick_val;
  logic                        emit;
  logic                        last_res;
  logic                        start_chain;
  logic                        shift_mode;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept_in   = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;

  // Read the requested byte while idle, the byte on the wire while sending
  assign rd_addr = (state_q == ST_IDLE) ? srcd_pkg::LEN_W'(in_item_i.bit_index[4:3]) : byte_q;

  srcd_shadow u_shadow (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (accept_in),
    .item_i    (in_item_i),
    .rd_addr_i (rd_addr),
    .status_o  (status)
  );

  // Step control
  always_comb begin
    start_chain = (status.send_n != '0) & (shift_present_q | latch_present_q);
    shift_mode  = chain_q & shift_present_q;
    last_res    = ~chain_q | ((byte_q == '0) & (~shift_present_q | (bit_q == 3'd0)));
    emit        = (state_q == ST_RUN) & tick_done & out_free;
    tick_load   = accept_in | (emit & ~last_res);
    if (((accept_in ? start_chain : chain_q) & shift_present_q) == 1'b1) begin
      tick_val = {half_period_q, 1'b0};
    end else begin
      tick_val = {1'b0, half_period_q};
    end
  end

  srcd_tick u_tick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (tick_load),
    .load_val_i (tick_val),
    .done_o     (tick_done)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q    <= srcd_pkg::HP_W'(8);
      shift_present_q  <= 1'b1;
      latch_present_q  <= 1'b1;
      clear_present_q  <= 1'b1;
      enable_present_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srcd_pkg::CFG_HALF_PERIOD:    half_period_q    <= cfg_data_i;
        srcd_pkg::CFG_SHIFT_PRESENT:  shift_present_q  <= cfg_data_i[0];
        srcd_pkg::CFG_LATCH_PRESENT:  latch_present_q  <= cfg_data_i[0];
        srcd_pkg::CFG_CLEAR_PRESENT:  clear_present_q  <= cfg_data_i[0];
        srcd_pkg::CFG_ENABLE_PRESENT: enable_present_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: start on an item, walk bytes high to low, bits MSB first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chain_q <= 1'b0;
      byte_q  <= '0;
      bit_q   <= '0;
      clr_q   <= 1'b0;
      rdv_q   <= 1'b0;
    end else if (accept_in) begin
      state_q <= ST_RUN;
      chain_q <= start_chain;
      byte_q  <= status.send_n - srcd_pkg::LEN_W'(1);
      bit_q   <= 3'd7;
      clr_q   <= (in_item_i.func == srcd_pkg::FUNC_CLEAR) & clear_present_q;
      rdv_q   <= (in_item_i.func == srcd_pkg::FUNC_READ) & status.rd_bit;
    end else if (emit) begin
      if (last_res) begin
        state_q <= ST_IDLE;
      end else if (shift_present_q) begin
        if (bit_q == 3'd0) begin
          bit_q  <= 3'd7;
          byte_q <= byte_q - srcd_pkg::LEN_W'(1);
        end else begin
          bit_q <= bit_q - 3'd1;
        end
      end else begin
        byte_q <= byte_q - srcd_pkg::LEN_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.shift_valid  <= shift_mode;
      out_q.serial_bit   <= shift_mode & status.rd_byte[bit_q];
      out_q.latch_pulse  <= chain_q & (shift_present_q ?
                            ((bit_q == 3'd0) & latch_present_q) : 1'b1);
      out_q.clear_pulse  <= ~chain_q & clr_q;
      out_q.enable_pin   <= enable_present_q ? ~status.enable : 1'b1;
      out_q.read_value   <= ~chain_q & rdv_q;
      out_q.enable_state <= status.enable;
      out_q.last         <= last_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[hdl/srcd_checker.sv]
// ----------------------------------------------------------------------------
// srcd_checker
// Port level checks for the shift register chain driver, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module srcd_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire srcd_pkg::out_item_t out_item_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // One item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // No serial level without a shift
  a_serial_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.shift_valid |-> !out_item_o.serial_bit)
    else $error("serial bit set on a non-shift result");

  // Shift results never carry clear or read data
  a_shift_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.shift_valid |->
      !out_item_o.clear_pulse && !out_item_o.read_value)
    else $error("shift result mixed with clear or read");

  // Clear and read make a single, final result
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.clear_pulse || out_item_o.read_value) |->
      out_item_o.last)
    else $error("clear or read result not marked last");

endmodule

bind shift_register_chain_driver_core srcd_checker u_srcd_checker (.*);

`default_nettype wire
